FILE: hw/rtl/pidl_pkg.sv
// Package for the positional insert/delete list.
// Holds mode and status codes and the controller/datapath command and status types.
// No dependencies.
package pidl_pkg;

    localparam int PIDL_CAPACITY = 128;

    localparam logic [2:0] MODE_CLEAR  = 3'd0;
    localparam logic [2:0] MODE_APPEND = 3'd1;
    localparam logic [2:0] MODE_READ   = 3'd2;
    localparam logic [2:0] MODE_INSERT = 3'd3;
    localparam logic [2:0] MODE_DELETE = 3'd4;

    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_BADPOS = 2'd1;
    localparam logic [1:0] STATUS_FULL   = 2'd2;

    typedef struct packed {
        logic       load_item;
        logic       st_load;
        logic [1:0] st_code;
        logic       rv_clr;
        logic       rv_cap;
        logic       idx_load_count;
        logic       idx_load_pos;
        logic       idx_inc;
        logic       idx_dec;
        logic       rd_pos;
        logic       rd_prev;
        logic       rd_next;
        logic       wr_value;
        logic       wr_rdata;
        logic       cnt_clr;
        logic       cnt_inc;
        logic       cnt_dec;
        logic       res_load;
    } pidl_cmd_t;

    typedef struct packed {
        logic [2:0] mode;
        logic       full;
        logic       pos_lt_cnt;
        logic       pos_gt_cnt;
        logic       idx_eq_pos;
        logic       idx_last;
        logic       out_free;
    } pidl_sts_t;

endpackage

FILE: hw/rtl/pidl_ctrl.sv
// Controller state machine for the positional insert/delete list.
// Depends on pidl_pkg; drives the datapath through pidl_cmd_t.
module pidl_ctrl import pidl_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  pidl_sts_t sts,
    output pidl_cmd_t cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_EXEC  = 4'd1;
    localparam logic [3:0] S_RDW   = 4'd2;
    localparam logic [3:0] S_PUT   = 4'd3;
    localparam logic [3:0] S_ISTEP = 4'd4;
    localparam logic [3:0] S_IWR   = 4'd5;
    localparam logic [3:0] S_DSTEP = 4'd6;
    localparam logic [3:0] S_DWR   = 4'd7;
    localparam logic [3:0] S_FIN   = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign s_tready = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_item = 1'b1;
                    state_next    = S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.st_load = 1'b1;
                cmd.st_code = STATUS_OK;
                cmd.rv_clr  = 1'b1;
                state_next  = S_FIN;
                case (sts.mode)
                    MODE_CLEAR: begin
                        cmd.cnt_clr = 1'b1;
                    end
                    MODE_APPEND: begin
                        if (sts.full) begin
                            cmd.st_code = STATUS_FULL;
                        end else begin
                            cmd.idx_load_count = 1'b1;
                            state_next         = S_PUT;
                        end
                    end
                    MODE_READ: begin
                        if (sts.pos_lt_cnt) begin
                            cmd.rd_pos = 1'b1;
                            state_next = S_RDW;
                        end else begin
                            cmd.st_code = STATUS_BADPOS;
                        end
                    end
                    MODE_INSERT: begin
                        if (sts.full) begin
                            cmd.st_code = STATUS_FULL;
                        end else if (sts.pos_gt_cnt) begin
                            cmd.st_code = STATUS_BADPOS;
                        end else begin
                            cmd.idx_load_count = 1'b1;
                            state_next         = S_ISTEP;
                        end
                    end
                    MODE_DELETE: begin
                        if (sts.pos_lt_cnt) begin
                            cmd.idx_load_pos = 1'b1;
                            state_next       = S_DSTEP;
                        end else begin
                            cmd.st_code = STATUS_BADPOS;
                        end
                    end
                    default: begin
                        cmd.st_code = STATUS_OK;
                    end
                endcase
            end
            S_RDW: begin
                cmd.rv_cap = 1'b1;
                state_next = S_FIN;
            end
            S_PUT: begin
                cmd.wr_value = 1'b1;
                cmd.cnt_inc  = 1'b1;
                state_next   = S_FIN;
            end
            S_ISTEP: begin
                if (sts.idx_eq_pos) begin
                    state_next = S_PUT;
                end else begin
                    cmd.rd_prev = 1'b1;
                    state_next  = S_IWR;
                end
            end
            S_IWR: begin
                cmd.wr_rdata = 1'b1;
                cmd.idx_dec  = 1'b1;
                state_next   = S_ISTEP;
            end
            S_DSTEP: begin
                if (sts.idx_last) begin
                    cmd.cnt_dec = 1'b1;
                    state_next  = S_FIN;
                end else begin
                    cmd.rd_next = 1'b1;
                    state_next  = S_DWR;
                end
            end
            S_DWR: begin
                cmd.wr_rdata = 1'b1;
                cmd.idx_inc  = 1'b1;
                state_next   = S_DSTEP;
            end
            S_FIN: begin
                if (sts.out_free) begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: hw/rtl/pidl_datapath.sv
// Datapath for the positional insert/delete list: entry memory, count, index and result register.
// Depends on pidl_pkg; commanded by pidl_ctrl.
module pidl_datapath import pidl_pkg::*; #(
    parameter int CAPACITY = PIDL_CAPACITY
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  pidl_cmd_t          cmd,
    output pidl_sts_t          sts,
    input  logic [2:0]         item_mode,
    input  logic [6:0]         item_position,
    input  logic signed [31:0] item_value,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [1:0]         m_status,
    output logic signed [31:0] m_read_value,
    output logic [7:0]         m_count_after
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam int WW = (CW > 8) ? CW : 8;

    logic [31:0]        mem [CAPACITY];
    logic [31:0]        rdata_reg;
    logic [2:0]         mode_reg;
    logic [6:0]         pos_reg;
    logic [31:0]        value_reg;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      idx_reg;
    logic [1:0]         st_reg;
    logic [31:0]        rv_reg;
    logic               out_valid_reg;
    logic [1:0]         out_status_reg;
    logic [31:0]        out_rv_reg;
    logic [7:0]         out_count_reg;

    logic [WW-1:0] pos_w;
    logic [WW-1:0] cnt_w;
    logic [WW-1:0] idx_w;
    logic [WW-1:0] idx_prev_w;
    logic [WW-1:0] idx_next_w;
    logic [AW-1:0] raddr;
    logic          rd_en;
    logic          wr_en;

    assign pos_w      = WW'(pos_reg);
    assign cnt_w      = WW'(count_reg);
    assign idx_w      = WW'(idx_reg);
    assign idx_prev_w = idx_w - WW'(1);
    assign idx_next_w = idx_w + WW'(1);

    assign sts.mode       = mode_reg;
    assign sts.full       = (cnt_w >= WW'(CAPACITY));
    assign sts.pos_lt_cnt = (pos_w < cnt_w);
    assign sts.pos_gt_cnt = (pos_w > cnt_w);
    assign sts.idx_eq_pos = (idx_w == pos_w);
    assign sts.idx_last   = (idx_next_w >= cnt_w);
    assign sts.out_free   = !out_valid_reg || m_tready;

    assign rd_en = cmd.rd_pos || cmd.rd_prev || cmd.rd_next;
    assign wr_en = cmd.wr_value || cmd.wr_rdata;

    always_comb begin
        if (cmd.rd_pos) begin
            raddr = pos_w[AW-1:0];
        end else if (cmd.rd_prev) begin
            raddr = idx_prev_w[AW-1:0];
        end else begin
            raddr = idx_next_w[AW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[idx_reg[AW-1:0]] <= cmd.wr_value ? value_reg : rdata_reg;
        end
        if (rd_en) begin
            rdata_reg <= mem[raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            mode_reg  <= item_mode;
            pos_reg   <= item_position;
            value_reg <= item_value;
        end
        if (cmd.idx_load_count) begin
            idx_reg <= count_reg;
        end else if (cmd.idx_load_pos) begin
            idx_reg <= pos_w[CW-1:0];
        end else if (cmd.idx_inc) begin
            idx_reg <= idx_reg + 1'b1;
        end else if (cmd.idx_dec) begin
            idx_reg <= idx_reg - 1'b1;
        end
        if (cmd.st_load) begin
            st_reg <= cmd.st_code;
        end
        if (cmd.rv_clr) begin
            rv_reg <= '0;
        end else if (cmd.rv_cap) begin
            rv_reg <= rdata_reg;
        end
        if (cmd.res_load) begin
            out_status_reg <= st_reg;
            out_rv_reg     <= rv_reg;
            out_count_reg  <= cnt_w[7:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.cnt_clr) begin
                count_reg <= '0;
            end else if (cmd.cnt_inc) begin
                count_reg <= count_reg + 1'b1;
            end else if (cmd.cnt_dec) begin
                count_reg <= count_reg - 1'b1;
            end
            if (cmd.res_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid      = out_valid_reg;
    assign m_status      = out_status_reg;
    assign m_read_value  = out_rv_reg;
    assign m_count_after = out_count_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_w <= WW'(CAPACITY))
        else $error("entry count exceeds capacity");

    a_inc_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.cnt_inc |-> !sts.full)
        else $error("count incremented on a full list");

    a_dec_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.cnt_dec |-> (count_reg != '0))
        else $error("count decremented on an empty list");

    a_res_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.res_load |-> sts.out_free)
        else $error("result overwrites an untaken transfer");

endmodule

FILE: hw/rtl/positional_insert_delete_list.sv
// Positional insert/delete list: top level joining pidl_ctrl and pidl_datapath.
// Insert shifts every entry from the position up by one place and delete shifts every entry
// after the position down by one place, both before the result is loaded. One item is handled
// at a time: the next input transfer is taken in the cycle after the result is loaded, and a
// stalled result holds the item.
// Reset clears the count and handshake state only; entry contents stay undefined, no clear pass.
module positional_insert_delete_list import pidl_pkg::*; #(
    parameter int CAPACITY = PIDL_CAPACITY
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [6:0] position, [38:7] value, [39] unused
    input  logic [2:0]  s_tuser,   // [2:0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] read_value, [39:32] count_after
    output logic [1:0]  m_tuser    // [1:0] status
);

    pidl_cmd_t          cmd;
    pidl_sts_t          sts;
    logic signed [31:0] read_value;
    logic [7:0]         count_after;

    pidl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pidl_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .item_mode     (s_tuser),
        .item_position (s_tdata[6:0]),
        .item_value    (s_tdata[38:7]),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_status      (m_tuser),
        .m_read_value  (read_value),
        .m_count_after (count_after)
    );

    assign m_tdata = {count_after, read_value};

endmodule
